[rtl/sd_spi_pkg.sv]
// Package for the SPI-mode SD host: command frames, reply codes, status codes.
// Used by sd_spi_init_and_sector_read; no dependencies.
package sd_spi_pkg;

  localparam int unsigned SectorBytes = 512;
  localparam int unsigned ByteCntW    = 10;
  localparam int unsigned FrameW      = 48;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;

  // Complete 48-bit frames; CMD0 and CMD8 carry valid CRCs, CMD55 and ACMD41 an FF byte
  localparam logic [FrameW-1:0] Cmd0Word   = 48'h400000000095;
  localparam logic [FrameW-1:0] Cmd8Word   = 48'h48000001AA87;
  localparam logic [FrameW-1:0] Cmd55Word  = 48'h7700000000FF;
  localparam logic [FrameW-1:0] Acmd41Word = 48'h6940000000FF;

  localparam logic [7:0] IdxCmd0   = Cmd0Word[47:40];
  localparam logic [7:0] IdxCmd8   = Cmd8Word[47:40];
  localparam logic [7:0] IdxCmd55  = Cmd55Word[47:40];
  localparam logic [7:0] IdxAcmd41 = Acmd41Word[47:40];
  localparam logic [7:0] IdxCmd17  = 8'h51;
  localparam logic [7:0] Cmd17Crc  = 8'hFF;

  localparam logic [7:0] StartToken = 8'hFE;
  localparam logic [7:0] ReplyIdle  = 8'h01;
  localparam logic [7:0] ReplyReady = 8'h00;

  localparam logic [7:0]  InitClockReset  = 8'd80;
  localparam logic [15:0] RetryLimitReset = 16'd1000;

  typedef enum logic [1:0] {
    CmdTick = 2'd0,
    CmdInit = 2'd1,
    CmdRead = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInitClocks = 2'd0,
    CfgRetryLimit = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StatusOk        = 3'd0,
    StatusCmd0Bad   = 3'd1,
    StatusCmd8Bad   = 3'd2,
    StatusAcmdTmo   = 3'd3,
    StatusWaitToken = 3'd4
  } status_e;

endpackage

[rtl/sd_spi_init_and_sector_read.sv]
// SPI-mode SD host controller, one SCLK period per request.
// Depends on sd_spi_pkg.
//
// Each input request is one SCLK pulse carrying the sampled MISO bit; the result gives
// CS and MOSI for that period plus any received sector byte and status. Requests are
// taken one per clock cycle: the whole phase/shift update is done in a single pass and
// lands in an output register, so each result appears in the cycle after its request, at
// one request per cycle while the consumer keeps up. A start-init request runs the idle
// clocks, CMD0, CMD8 and CMD55/ACMD41 rounds; a start-read request sends CMD17, hunts
// for the start token and streams the sector. Errors stick until reset. Configuration
// writes are taken at any time and apply from the next request.
module sd_spi_init_and_sector_read
  import sd_spi_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic [31:0]         sector_i,
  input  logic                miso_bit_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                chip_select_o,
  output logic                mosi_bit_o,
  output logic                data_valid_o,
  output logic [7:0]          data_byte_o,
  output logic                last_byte_o,
  output logic                busy_res_o,
  output logic [2:0]          status_o,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    PhIdle,
    PhInitClk,
    PhSend,
    PhGap,
    PhReply,
    PhTrail,
    PhToken,
    PhData,
    PhCrc
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [FrameW-1:0]   shift_q, shift_d;
  logic [2:0]          bit_q, bit_d;
  logic [ByteCntW-1:0] byc_q, byc_d;
  logic [7:0]          rx_q, rx_d;
  logic [7:0]          first_q, first_d;
  logic [15:0]         retry_q, retry_d;
  logic [1:0]          err_q, err_d;
  logic [7:0]          init_clocks_q;
  logic [15:0]         retry_limit_q;

  logic                out_valid_q;
  logic                cs_q, cs_d;
  logic                mosi_q, mosi_d;
  logic                dv_q, dv_d;
  logic [7:0]          db_q, db_d;
  logic                last_q, last_d;
  logic [2:0]          status_d;
  status_e             status_q;

  logic                accept;
  logic                load_req;
  logic [FrameW-1:0]   load_word;
  logic [7:0]          idx;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    phase_d   = phase_q;
    shift_d   = shift_q;
    bit_d     = bit_q;
    byc_d     = byc_q;
    rx_d      = rx_q;
    first_d   = first_q;
    retry_d   = retry_q;
    err_d     = err_q;
    cs_d      = 1'b1;
    mosi_d    = 1'b1;
    dv_d      = 1'b0;
    db_d      = 8'd0;
    last_d    = 1'b0;
    load_req  = 1'b0;
    load_word = Cmd55Word;

    // A start request is itself the first clock of its sequence
    if (phase_q == PhIdle && err_q == 2'd0) begin
      if (cmd_i == CmdInit) begin
        phase_d = PhInitClk;
        byc_d   = '0;
        bit_d   = '0;
      end else if (cmd_i == CmdRead) begin
        shift_d = {IdxCmd17, sector_i, Cmd17Crc};
        bit_d   = '0;
        byc_d   = '0;
        phase_d = PhSend;
      end
    end

    idx = shift_d[FrameW-1 -: 8];

    unique case (phase_d)
      PhIdle: begin
      end
      PhInitClk: begin
        byc_d = byc_d + ByteCntW'(1);
        if (byc_d >= ByteCntW'(init_clocks_q)) begin
          load_req  = 1'b1;
          load_word = Cmd0Word;
        end
      end
      PhSend: begin
        cs_d    = 1'b0;
        mosi_d  = shift_d[FrameW-1];
        shift_d = {shift_d[FrameW-2:0], shift_d[FrameW-1]};
        bit_d   = bit_d + 3'd1;
        if (bit_d == 3'd0) begin
          byc_d = byc_d + ByteCntW'(1);
          if (byc_d >= ByteCntW'(FrameW / 8)) begin
            phase_d = PhGap;
            byc_d   = '0;
          end
        end
      end
      PhGap: begin
        cs_d  = 1'b0;
        bit_d = bit_d + 3'd1;
        if (bit_d == 3'd0) begin
          phase_d = PhReply;
          rx_d    = '0;
          byc_d   = '0;
        end
      end
      PhReply: begin
        cs_d  = 1'b0;
        rx_d  = {rx_d[6:0], miso_bit_i};
        bit_d = bit_d + 3'd1;
        if (bit_d == 3'd0) begin
          if (byc_d == '0) first_d = rx_d;
          byc_d = byc_d + ByteCntW'(1);
          // CMD8 answers with R7 (five bytes), the rest with R1
          if (byc_d >= ((idx == IdxCmd8) ? ByteCntW'(5) : ByteCntW'(1))) begin
            byc_d   = '0;
            phase_d = (idx == IdxCmd17) ? PhToken : PhTrail;
          end
        end
      end
      PhTrail: begin
        bit_d = bit_d + 3'd1;
        if (bit_d == 3'd0) begin
          unique case (idx)
            IdxCmd0: begin
              if (first_d == ReplyIdle) begin
                load_req  = 1'b1;
                load_word = Cmd8Word;
              end else begin
                err_d   = 2'(StatusCmd0Bad);
                phase_d = PhIdle;
              end
            end
            IdxCmd8: begin
              if (first_d == ReplyIdle) begin
                retry_d   = '0;
                load_req  = 1'b1;
                load_word = Cmd55Word;
              end else begin
                err_d   = 2'(StatusCmd8Bad);
                phase_d = PhIdle;
              end
            end
            IdxCmd55: begin
              load_req  = 1'b1;
              load_word = Acmd41Word;
            end
            IdxAcmd41: begin
              if (first_d == ReplyReady) begin
                phase_d = PhIdle;
              end else begin
                retry_d = retry_d + 16'd1;
                if (retry_d >= retry_limit_q) begin
                  err_d   = 2'(StatusAcmdTmo);
                  phase_d = PhIdle;
                end else begin
                  load_req  = 1'b1;
                  load_word = Cmd55Word;
                end
              end
            end
            default: phase_d = PhIdle;
          endcase
        end
      end
      PhToken: begin
        cs_d  = 1'b0;
        rx_d  = {rx_d[6:0], miso_bit_i};
        bit_d = bit_d + 3'd1;
        if (bit_d == 3'd0 && rx_d == StartToken) begin
          phase_d = PhData;
          byc_d   = '0;
        end
      end
      PhData: begin
        cs_d  = 1'b0;
        rx_d  = {rx_d[6:0], miso_bit_i};
        bit_d = bit_d + 3'd1;
        if (bit_d == 3'd0) begin
          dv_d = 1'b1;
          db_d = rx_d;
          if (byc_d >= ByteCntW'(SectorBytes - 1)) begin
            last_d  = 1'b1;
            phase_d = PhCrc;
            byc_d   = '0;
          end else begin
            byc_d = byc_d + ByteCntW'(1);
          end
        end
      end
      PhCrc: begin
        cs_d  = 1'b0;
        rx_d  = {rx_d[6:0], miso_bit_i};
        bit_d = bit_d + 3'd1;
        if (bit_d == 3'd0) begin
          byc_d = byc_d + ByteCntW'(1);
          if (byc_d >= ByteCntW'(2)) begin
            phase_d = PhTrail;
            byc_d   = '0;
          end
        end
      end
      default: phase_d = PhIdle;
    endcase

    if (load_req) begin
      shift_d = load_word;
      bit_d   = '0;
      byc_d   = '0;
      phase_d = PhSend;
    end

    if (err_d != 2'd0)          status_d = {1'b0, err_d};
    else if (phase_d == PhToken) status_d = StatusWaitToken;
    else                         status_d = StatusOk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      shift_q       <= '0;
      bit_q         <= '0;
      byc_q         <= '0;
      rx_q          <= '0;
      first_q       <= '0;
      retry_q       <= '0;
      err_q         <= '0;
      init_clocks_q <= InitClockReset;
      retry_limit_q <= RetryLimitReset;
      out_valid_q   <= 1'b0;
      cs_q          <= 1'b1;
      mosi_q        <= 1'b1;
      dv_q          <= 1'b0;
      db_q          <= '0;
      last_q        <= 1'b0;
      status_q      <= StatusOk;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgInitClocks) init_clocks_q <= cfg_data_i[7:0];
        if (cfg_index_i == CfgRetryLimit) retry_limit_q <= cfg_data_i;
      end
      if (accept) begin
        phase_q     <= phase_d;
        shift_q     <= shift_d;
        bit_q       <= bit_d;
        byc_q       <= byc_d;
        rx_q        <= rx_d;
        first_q     <= first_d;
        retry_q     <= retry_d;
        err_q       <= err_d;
        out_valid_q <= 1'b1;
        cs_q        <= cs_d;
        mosi_q      <= mosi_d;
        dv_q        <= dv_d;
        db_q        <= db_d;
        last_q      <= last_d;
        status_q    <= status_e'(status_d);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign chip_select_o = cs_q;
  assign mosi_bit_o    = mosi_q;
  assign data_valid_o  = dv_q;
  assign data_byte_o   = db_q;
  assign last_byte_o   = last_q;
  assign busy_res_o    = (phase_q != PhIdle);
  assign status_o      = status_q;

endmodule
